[hw/rtl/cross_neighbour_smoothing_filter_defines.svh]
// Assertion macros for the cross-neighbour smoothing filter RTL.
// No dependencies; taken in by every file that carries assertions.
`ifndef CROSS_NEIGHBOUR_SMOOTHING_FILTER_DEFINES_SVH
`define CROSS_NEIGHBOUR_SMOOTHING_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CNSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cnsf: assertion failed");
// next-cycle implication
`define CNSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cnsf: assertion failed");
`else
`define CNSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CNSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/cnsf_pkg.sv]
// Shared types, constants and helpers of the cross-neighbour smoothing filter.
// No dependencies; used by the line store, the lanes, the merge queue and the top level.
package cnsf_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET = 11'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // pixel layout: four 16-bit channels, red in the low bits
    localparam int CH_W    = 16;
    localparam int NUM_CH  = 4;
    localparam int PIX_W   = CH_W * NUM_CH;
    localparam int SUM_W   = CH_W + 2;
    localparam int COORD_W = 10;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [COORD_W-1:0] t_coord;

    // lanes: one per result an input pixel can cause
    localparam int NUM_LANES      = 3;
    localparam int LANE_CW        = 2;
    localparam int LANE_PREV_ROW  = 0;  // pixel above the incoming one
    localparam int LANE_LAST_ROW  = 1;  // last row, pixel to the left
    localparam int LANE_FRAME_END = 2;  // final pixel of the frame

    // result queue
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // line store slots rotate 0, 1, 2
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_FIRST = 2'd0;
    localparam t_slot SLOT_LAST  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        t_coord          column;
        t_coord          row;
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
        logic            frame_done;
    } t_result;

    // neighbours and position of one pixel to smooth
    typedef struct packed {
        logic   valid;
        t_pix   left;
        t_pix   right;
        t_pix   up;
        t_pix   down;
        t_coord column;
        t_coord row;
        logic   frame_done;
    } t_lane_req;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_lane_out;

    function automatic t_slot slot_inc(input t_slot s);
        return (s == SLOT_LAST) ? SLOT_FIRST : s + 2'd1;
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        return (s == SLOT_FIRST) ? SLOT_LAST : s - 2'd1;
    endfunction

endpackage

[hw/rtl/cnsf_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Instantiated with cnsf_pkg::t_pix_in for pixels and cnsf_pkg::t_result for results.
interface cnsf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/cross_neighbour_smoothing_filter.sv]
// Cross-neighbour smoothing filter, top level: counters, line window, lanes, merge.
// Depends on cnsf_pkg, cnsf_stream_if, cnsf_line_store, cnsf_lane, cnsf_merge.
//
// Takes one RGBA pixel per request in raster order and returns each pixel as the
// truncated mean of its left, right, upper and lower neighbours, an edge neighbour
// replaced by the pixel itself. Pixel (x, y) comes out when (x, y+1) is taken; in
// the last row (x-1, y) comes out with (x, y), and the final pixel also brings
// itself, flagged by frame_done. Every result carries its own column and row.
// An input pixel is taken every clock as long as results drain at one per clock;
// its results pass the lane request and result registers and the result queue
// before they are offered. In the last row most pixels yield two results, so
// there the single result port sets the pace, buffered by an eight-entry result
// queue. The line store needs no clearing after reset. Frame width and height are
// written through the configuration port between frames; zero acts as one and
// values above MAX_WIDTH or MAX_HEIGHT act as the maximum. Further smoothing
// passes are made by streaming the result frame in again.
`include "cross_neighbour_smoothing_filter_defines.svh"
module cross_neighbour_smoothing_filter #(
    parameter int MAX_WIDTH  = cnsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cnsf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cnsf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cnsf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    cnsf_stream_if.sink                       i_pix,
    cnsf_stream_if.source                     o_res
);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = CW + 1;
    localparam int HW     = RW + 1;
    localparam int AW     = CW + 2;
    localparam int LCW    = cnsf_pkg::LANE_CW;
    localparam int QCW    = cnsf_pkg::QCW;
    localparam int QDEPTH = cnsf_pkg::QDEPTH;
    localparam int NL     = cnsf_pkg::NUM_LANES;

    // configuration registers
    logic [cnsf_pkg::CFG_DATA_W-1:0] r_cfg_width;
    logic [cnsf_pkg::CFG_DATA_W-1:0] r_cfg_height;
    logic [WW-1:0]                   w_eff;
    logic [HW-1:0]                   h_eff;

    // position and line window
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    cnsf_pkg::t_slot   r_slot, n_slot;
    cnsf_pkg::t_pix    r_win_c, r_win_l, r_head0, r_p1, r_p2;
    cnsf_pkg::t_pix    pix;
    cnsf_pkg::t_pix    rd_a, rd_b;
    logic [WW-1:0]     x1;
    logic [HW-1:0]     y1;
    logic              acc, last_col, last_row;
    logic              has_up1, has_up2, col_gt0, col_gt1, col_in_frame;
    logic [AW-1:0]     waddr, raddr_a, raddr_b;

    // lane requests and credits
    cnsf_pkg::t_lane_req                 n_req [NL];
    cnsf_pkg::t_lane_req                 r_req [NL];
    cnsf_pkg::t_lane_out [NL-1:0]        lane_out;
    logic [NL-1:0]                       n_valid;
    logic [LCW-1:0]                      acc_cnt;
    logic [QCW-1:0]                      r_credit;
    logic                                pop;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= cnsf_pkg::CFG_RESET;
            r_cfg_height <= cnsf_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (cnsf_pkg::t_cfg_idx'(i_cfg_idx))
                cnsf_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                cnsf_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = HW'(1);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_height);
        end
    end

    assign acc          = i_pix.valid && i_pix.ready;
    assign pix          = {i_pix.data.alpha_in, i_pix.data.blue_in,
                           i_pix.data.green_in, i_pix.data.red_in};
    assign x1           = WW'(r_col) + WW'(1);
    assign y1           = HW'(r_row) + HW'(1);
    assign last_col     = (x1 >= w_eff);
    assign last_row     = (y1 >= h_eff);
    assign has_up1      = (r_row != '0);
    assign has_up2      = (r_row > RW'(1));
    assign col_gt0      = (r_col != '0);
    assign col_gt1      = (r_col > CW'(1));
    assign col_in_frame = (WW'(r_col) < w_eff);

    // raster position for the next request
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (acc) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row  = '0;
                    n_slot = cnsf_pkg::SLOT_FIRST;
                end else begin
                    n_row  = r_row + RW'(1);
                    n_slot = cnsf_pkg::slot_inc(r_slot);
                end
            end else begin
                n_col = x1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= cnsf_pkg::SLOT_FIRST;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    // store the pixel, prefetch what the next position needs:
    // row above at the right neighbour, two rows above at the same column
    assign waddr   = {r_slot, r_col};
    assign raddr_a = {cnsf_pkg::slot_dec(n_slot), n_col + CW'(1)};
    assign raddr_b = {cnsf_pkg::slot_dec(cnsf_pkg::slot_dec(n_slot)), n_col};

    cnsf_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (acc),
        .i_waddr   (waddr),
        .i_wdata   (pix),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // sliding window: row above at x-1 and x, current row at x-1 and x-2, row head
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (!col_gt0) begin
                r_head0 <= pix;
            end
            r_p1 <= pix;
            r_p2 <= r_p1;
            if (last_col) begin
                r_win_c <= col_gt0 ? r_head0 : pix;
            end else begin
                r_win_l <= r_win_c;
                r_win_c <= rd_a;
            end
        end
    end

    // neighbour selection for the three lanes
    always_comb begin
        // pixel of the row above
        n_req[cnsf_pkg::LANE_PREV_ROW].valid      = acc && has_up1;
        n_req[cnsf_pkg::LANE_PREV_ROW].left       = col_gt0 ? r_win_l : r_win_c;
        n_req[cnsf_pkg::LANE_PREV_ROW].right      = last_col ? r_win_c : rd_a;
        n_req[cnsf_pkg::LANE_PREV_ROW].up         = has_up2 ? rd_b : r_win_c;
        n_req[cnsf_pkg::LANE_PREV_ROW].down       = pix;
        n_req[cnsf_pkg::LANE_PREV_ROW].column     = cnsf_pkg::t_coord'(r_col);
        n_req[cnsf_pkg::LANE_PREV_ROW].row        = cnsf_pkg::t_coord'(r_row - RW'(1));
        n_req[cnsf_pkg::LANE_PREV_ROW].frame_done = 1'b0;

        // last row: pixel to the left of the incoming one
        n_req[cnsf_pkg::LANE_LAST_ROW].valid      = acc && last_row && col_gt0;
        n_req[cnsf_pkg::LANE_LAST_ROW].left       = col_gt1 ? r_p2 : r_p1;
        n_req[cnsf_pkg::LANE_LAST_ROW].right      = col_in_frame ? pix : r_p1;
        n_req[cnsf_pkg::LANE_LAST_ROW].up         = has_up1 ? r_win_l : r_p1;
        n_req[cnsf_pkg::LANE_LAST_ROW].down       = r_p1;
        n_req[cnsf_pkg::LANE_LAST_ROW].column     = cnsf_pkg::t_coord'(r_col - CW'(1));
        n_req[cnsf_pkg::LANE_LAST_ROW].row        = cnsf_pkg::t_coord'(r_row);
        n_req[cnsf_pkg::LANE_LAST_ROW].frame_done = 1'b0;

        // final pixel of the frame
        n_req[cnsf_pkg::LANE_FRAME_END].valid      = acc && last_row && last_col;
        n_req[cnsf_pkg::LANE_FRAME_END].left       = col_gt0 ? r_p1 : pix;
        n_req[cnsf_pkg::LANE_FRAME_END].right      = pix;
        n_req[cnsf_pkg::LANE_FRAME_END].up         = has_up1 ? r_win_c : pix;
        n_req[cnsf_pkg::LANE_FRAME_END].down       = pix;
        n_req[cnsf_pkg::LANE_FRAME_END].column     = cnsf_pkg::t_coord'(r_col);
        n_req[cnsf_pkg::LANE_FRAME_END].row        = cnsf_pkg::t_coord'(r_row);
        n_req[cnsf_pkg::LANE_FRAME_END].frame_done = 1'b1;

        for (int i = 0; i < NL; i++) begin
            n_valid[i] = n_req[i].valid;
        end
    end

    // lane request registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NL; i++) begin
            if (!i_rst_n) begin
                r_req[i].valid <= 1'b0;
            end else begin
                r_req[i] <= n_req[i];
            end
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        cnsf_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req[g]),
            .o_res   (lane_out[g])
        );
    end

    cnsf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (lane_out),
        .o_res   (o_res)
    );

    // queue credits: every result in flight or queued holds one entry
    assign acc_cnt = LCW'($countones(n_valid));
    assign pop     = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + QCW'(acc_cnt) - QCW'(pop);
        end
    end

    assign i_pix.ready = (r_credit <= QCW'(QDEPTH - NL));

    `CNSF_ASSERT_IMPL(a_credit_bound, i_clk, i_rst_n, 1'b1, r_credit <= QCW'(QDEPTH))
    `CNSF_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, acc && last_col && last_row,
        (r_row == '0) && (r_col == '0) && (r_slot == cnsf_pkg::SLOT_FIRST))
    `CNSF_ASSERT_NEXT(a_prev_row_issued, i_clk, i_rst_n, acc && has_up1,
        r_req[cnsf_pkg::LANE_PREV_ROW].valid)
endmodule

[hw/rtl/cnsf_line_store.sv]
// Three line stores in one memory: one write and two registered reads per request.
// Depends on cnsf_pkg; port A forwards a write to the same address in the same cycle.
module cnsf_line_store #(
    parameter int MAX_WIDTH = cnsf_pkg::DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [$clog2(MAX_WIDTH)+1:0] i_waddr,
    input  cnsf_pkg::t_pix        i_wdata,
    input  logic [$clog2(MAX_WIDTH)+1:0] i_raddr_a,
    input  logic [$clog2(MAX_WIDTH)+1:0] i_raddr_b,
    output cnsf_pkg::t_pix        o_rdata_a,
    output cnsf_pkg::t_pix        o_rdata_b
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 3 << CW;

    cnsf_pkg::t_pix r_mem [DEPTH];
    cnsf_pkg::t_pix r_rd_a;
    cnsf_pkg::t_pix r_rd_b;
    cnsf_pkg::t_pix r_byp_data;
    logic           r_byp;

    // storage and read ports
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_waddr] <= i_wdata;
            r_rd_a         <= r_mem[i_raddr_a];
            r_rd_b         <= r_mem[i_raddr_b];
            r_byp_data     <= i_wdata;
        end
    end

    // write-to-read forwarding on port A (row turnaround of a frame two pixels wide)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_en) begin
            r_byp <= (i_waddr == i_raddr_a);
        end
    end

    assign o_rdata_a = r_byp ? r_byp_data : r_rd_a;
    assign o_rdata_b = r_rd_b;
endmodule

[hw/rtl/cnsf_lane.sv]
// One smoothing lane: per-channel sum of four neighbours, truncated mean, registered.
// Depends on cnsf_pkg.
module cnsf_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cnsf_pkg::t_lane_req i_req,
    output cnsf_pkg::t_lane_out o_res
);
    localparam int CH_W  = cnsf_pkg::CH_W;
    localparam int SUM_W = cnsf_pkg::SUM_W;

    logic [SUM_W-1:0]    sum [cnsf_pkg::NUM_CH];
    logic [CH_W-1:0]     mean [cnsf_pkg::NUM_CH];
    cnsf_pkg::t_result   n_res;
    cnsf_pkg::t_result   r_res;
    logic                r_valid;

    // four-input add per channel, drop two bits
    always_comb begin
        for (int ch = 0; ch < cnsf_pkg::NUM_CH; ch++) begin
            sum[ch] = SUM_W'(i_req.left[ch*CH_W +: CH_W])
                    + SUM_W'(i_req.right[ch*CH_W +: CH_W])
                    + SUM_W'(i_req.up[ch*CH_W +: CH_W])
                    + SUM_W'(i_req.down[ch*CH_W +: CH_W]);
            mean[ch] = sum[ch][SUM_W-1:2];
        end
    end

    always_comb begin
        n_res.column     = i_req.column;
        n_res.row        = i_req.row;
        n_res.red_out    = mean[0];
        n_res.green_out  = mean[1];
        n_res.blue_out   = mean[2];
        n_res.alpha_out  = mean[3];
        n_res.frame_done = i_req.frame_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res.valid = r_valid;
    assign o_res.res   = r_res;
endmodule

[hw/rtl/cnsf_merge.sv]
// Merge stage: packs the lane results in lane order into a result queue.
// Depends on cnsf_pkg, cnsf_stream_if and the assertion macro header.
`include "cross_neighbour_smoothing_filter_defines.svh"
module cnsf_merge (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  cnsf_pkg::t_lane_out [cnsf_pkg::NUM_LANES-1:0] i_lane,
    cnsf_stream_if.source                                  o_res
);
    localparam int LCW    = cnsf_pkg::LANE_CW;
    localparam int QAW    = cnsf_pkg::QAW;
    localparam int QCW    = cnsf_pkg::QCW;
    localparam int QDEPTH = cnsf_pkg::QDEPTH;

    cnsf_pkg::t_result r_q [QDEPTH];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QCW-1:0]    r_cnt;
    logic [LCW-1:0]    pos [cnsf_pkg::NUM_LANES];
    logic [LCW-1:0]    push_cnt;
    logic              pop;

    // slot of each valid lane after compaction
    always_comb begin
        logic [LCW-1:0] run;
        run = '0;
        for (int i = 0; i < cnsf_pkg::NUM_LANES; i++) begin
            pos[i] = run;
            run    = run + LCW'(i_lane[i].valid);
        end
        push_cnt = run;
    end

    assign pop = o_res.valid && o_res.ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < cnsf_pkg::NUM_LANES; i++) begin
            if (i_lane[i].valid) begin
                r_q[r_wp + QAW'(pos[i])] <= i_lane[i].res;
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QAW'(push_cnt);
            r_rp  <= r_rp + QAW'(pop);
            r_cnt <= r_cnt + QCW'(push_cnt) - QCW'(pop);
        end
    end

    assign o_res.valid = (r_cnt != '0);
    assign o_res.data  = r_q[r_rp];

    `CNSF_ASSERT_IMPL(a_queue_no_overflow, i_clk, i_rst_n, 1'b1,
        (int'(r_cnt) + int'(push_cnt)) <= (QDEPTH + int'(pop)))
    `CNSF_ASSERT_NEXT(a_queue_fill_tracks, i_clk, i_rst_n, pop && (push_cnt == '0),
        r_cnt == $past(r_cnt) - QCW'(1))
endmodule
